// ----- src/rrs_pkg.sv -----
// Package for the RIP-relative reference scanner.
// Holds word types, register indexes, opcode constants and the start test.
// No dependencies.
`default_nettype none

package rrs_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_LIMIT    = 2'd1;

    // Result word kinds
    localparam logic KIND_REFERENCE = 1'b0;
    localparam logic KIND_SUMMARY   = 1'b1;

    // Opcode and ModR/M constants
    localparam logic [7:0] OP_GROUP5     = 8'hFF;
    localparam logic [7:0] MODRM_CALL    = 8'h15;
    localparam logic [7:0] MODRM_JMP     = 8'h25;
    localparam logic [7:0] REX_W_LO      = 8'h48;
    localparam logic [7:0] REX_W_HI      = 8'h4F;
    localparam logic [7:0] MODRM_MASK    = 8'hC7;
    localparam logic [7:0] MODRM_RIP     = 8'h05;
    localparam logic [7:0] OP_MOV_LOAD   = 8'h8B;
    localparam logic [7:0] OP_LEA        = 8'h8D;
    localparam logic [7:0] OP_CMP        = 8'h3B;
    localparam logic [7:0] OP_TEST       = 8'h85;
    localparam logic [7:0] OP_XOR        = 8'h30;
    localparam logic [7:0] OP_MOV_STORE8 = 8'h88;
    localparam logic [7:0] OP_MOV_STORE  = 8'h89;
    localparam logic [7:0] OP_MOV_LOAD8  = 8'h8A;
    localparam logic [7:0] OP_CMP8       = 8'h3A;
    localparam logic [7:0] OP_TEST8      = 8'h84;

    // ALU groups: six opcodes from each of these
    localparam logic [7:0] OP_ADD         = 8'h00;
    localparam logic [7:0] OP_OR          = 8'h08;
    localparam logic [7:0] OP_AND         = 8'h20;
    localparam logic [7:0] OP_SUB         = 8'h28;
    localparam logic [7:0] ALU_GROUP_SIZE = 8'd6;

    // Output queue depth; two free slots are needed to take a byte
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic               item_kind;
        logic [63:0]        site_address;
        logic signed [31:0] displacement;
        logic               data_ref;
        logic [15:0]        reference_total;
    } t_out_word;

    // Up to two result words per byte; v1 only with v0
    typedef struct packed {
        logic      v0;
        logic      v1;
        t_out_word w0;
        t_out_word w1;
    } t_push;

    // Outcome of one start test and the scan state it leaves
    typedef struct packed {
        logic        hit;
        logic        data;
        logic [31:0] disp;
        logic [2:0]  skip;
        logic [15:0] refs;
        logic        lim;
    } t_test_res;

    function automatic logic alu_group_hit(input logic [7:0] op, input logic [7:0] group);
        logic [7:0] diff;
        diff = op - group;
        return diff < ALU_GROUP_SIZE;
    endfunction

    function automatic logic listed_opcode(input logic [7:0] op);
        return (op == OP_MOV_STORE8) || (op == OP_MOV_STORE) || (op == OP_MOV_LOAD8) ||
               (op == OP_MOV_LOAD) || (op == OP_LEA) || (op == OP_CMP8) || (op == OP_CMP) ||
               (op == OP_TEST8) || (op == OP_TEST) ||
               alu_group_hit(op, OP_ADD) || alu_group_hit(op, OP_OR) ||
               alu_group_hit(op, OP_AND) || alu_group_hit(op, OP_SUB) ||
               alu_group_hit(op, OP_XOR);
    endfunction

    // Test the start at w[0]; full means seven section bytes are present,
    // otherwise six.
    function automatic t_test_res test_start(
        input logic [6:0][7:0] w,
        input logic            full,
        input logic            lim,
        input logic [15:0]     refs,
        input logic [15:0]     limit,
        input logic [2:0]      skip
    );
        t_test_res  res;
        logic       ff_hit;
        logic       pre;
        logic [7:0] op;
        logic [7:0] modrm;
        logic       mod_hit;
        logic [15:0] refs_inc;

        res.hit  = 1'b0;
        res.data = 1'b0;
        res.disp = '0;
        res.skip = skip;
        res.refs = refs;
        res.lim  = lim;

        ff_hit   = (w[0] == OP_GROUP5) && ((w[1] == MODRM_CALL) || (w[1] == MODRM_JMP));
        pre      = (w[0] >= REX_W_LO) && (w[0] <= REX_W_HI);
        op       = pre ? w[1] : w[0];
        modrm    = pre ? w[2] : w[1];
        mod_hit  = ((modrm & MODRM_MASK) == MODRM_RIP) && listed_opcode(op) && (!pre || full);
        refs_inc = refs + 16'd1;

        if (lim || (refs >= limit)) begin
            res.lim = 1'b1;
        end else if (skip != 3'd0) begin
            res.skip = skip - 3'd1;
        end else if (ff_hit) begin
            res.hit  = 1'b1;
            res.disp = {w[5], w[4], w[3], w[2]};
            res.skip = 3'd5;
            res.refs = refs_inc;
            res.lim  = (refs_inc >= limit);
        end else if (mod_hit) begin
            res.hit  = 1'b1;
            res.data = (op != OP_LEA);
            res.disp = pre ? {w[6], w[5], w[4], w[3]} : {w[5], w[4], w[3], w[2]};
            res.skip = pre ? 3'd6 : 3'd5;
            res.refs = refs_inc;
            res.lim  = (refs_inc >= limit);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/rrs_scan.sv -----
// Scan core: byte window, position, skip and limit state, start tests.
// Depends on rrs_pkg.
`default_nettype none

module rrs_scan #(
    parameter int POSITION_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire rrs_pkg::t_in_word i_word,
    input  wire [63:0]             i_base,
    input  wire [15:0]             i_limit,
    output rrs_pkg::t_push         o_push
);
    import rrs_pkg::*;

    logic [6:0][7:0]            r_win;
    logic [6:0][7:0]            n_win;
    logic [2:0]                 r_fill;
    logic [2:0]                 n_fill;
    logic [POSITION_WIDTH-1:0]  r_pos;
    logic [2:0]                 r_skip;
    logic [15:0]                r_refs;
    logic                       r_lim;

    logic                       en1;
    logic                       en2;
    logic [6:0][7:0]            win2;
    t_test_res                  t1;
    t_test_res                  t2;
    t_test_res                  st0;
    t_test_res                  st1;
    t_test_res                  st2;
    logic [POSITION_WIDTH-1:0]  off1;
    logic [POSITION_WIDTH-1:0]  off2;
    t_out_word                  ref1;
    t_out_word                  ref2;
    t_out_word                  summ;

    assign n_win  = {i_word.code_byte, r_win[6:1]};
    assign n_fill = (r_fill == 3'd7) ? 3'd7 : r_fill + 3'd1;
    assign en1    = (n_fill == 3'd7);
    assign en2    = i_word.last_byte && (n_fill >= 3'd6);
    assign win2   = {8'h00, n_win[6:1]};
    assign off1   = r_pos - POSITION_WIDTH'(6);
    assign off2   = r_pos - POSITION_WIDTH'(5);

    always_comb begin
        st0.hit  = 1'b0;
        st0.data = 1'b0;
        st0.disp = '0;
        st0.skip = r_skip;
        st0.refs = r_refs;
        st0.lim  = r_lim;
        t1  = test_start(n_win, 1'b1, st0.lim, st0.refs, i_limit, st0.skip);
        st1 = en1 ? t1 : st0;
        t2  = test_start(win2, 1'b0, st1.lim, st1.refs, i_limit, st1.skip);
        st2 = en2 ? t2 : st1;
    end

    always_comb begin
        ref1.item_kind       = KIND_REFERENCE;
        ref1.site_address    = i_base + 64'(off1);
        ref1.displacement    = signed'(t1.disp);
        ref1.data_ref        = t1.data;
        ref1.reference_total = '0;

        ref2.item_kind       = KIND_REFERENCE;
        ref2.site_address    = i_base + 64'(off2);
        ref2.displacement    = signed'(t2.disp);
        ref2.data_ref        = t2.data;
        ref2.reference_total = '0;

        summ.item_kind       = KIND_SUMMARY;
        summ.site_address    = '0;
        summ.displacement    = '0;
        summ.data_ref        = 1'b0;
        summ.reference_total = st2.refs;
    end

    // A hit skips at least five starts, so the two tests never both hit.
    always_comb begin
        logic h1;
        logic h2;
        h1 = en1 && t1.hit;
        h2 = en2 && t2.hit;
        o_push.v0 = i_adv && (h1 || h2 || i_word.last_byte);
        o_push.v1 = i_adv && (h1 || h2) && i_word.last_byte;
        o_push.w0 = h1 ? ref1 : (h2 ? ref2 : summ);
        o_push.w1 = summ;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
            r_skip <= '0;
            r_refs <= '0;
            r_lim  <= 1'b0;
        end else if (i_adv) begin
            if (i_word.last_byte) begin
                r_fill <= '0;
                r_pos  <= '0;
                r_skip <= '0;
                r_refs <= '0;
                r_lim  <= 1'b0;
            end else begin
                r_fill <= n_fill;
                r_pos  <= r_pos + POSITION_WIDTH'(1);
                r_skip <= st2.skip;
                r_refs <= st2.refs;
                r_lim  <= st2.lim;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/rrs_outq.sv -----
// Result queue: takes up to two result words per cycle, hands out one.
// Depends on rrs_pkg.
`default_nettype none

module rrs_outq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire rrs_pkg::t_push i_push,
    output logic                o_room,
    output logic                o_valid,
    input  wire                 i_ready,
    output rrs_pkg::t_out_word  o_word
);
    import rrs_pkg::*;

    t_out_word             r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr;
    logic [OUTQ_PTR_W-1:0] r_rd;
    logic [OUTQ_PTR_W:0]   r_cnt;
    logic                  pop;
    logic [OUTQ_PTR_W:0]   n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_cnt <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - 2));
    assign n_cnt   = r_cnt + (OUTQ_PTR_W+1)'(i_push.v0) + (OUTQ_PTR_W+1)'(i_push.v1)
                   - (OUTQ_PTR_W+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.v1) begin
            r_mem[r_wr + OUTQ_PTR_W'(1)] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OUTQ_PTR_W'(i_push.v0) + OUTQ_PTR_W'(i_push.v1);
            r_rd  <= r_rd + OUTQ_PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- src/rip_relative_reference_scanner_unit.sv -----
// Top level of the RIP-relative reference scanner.
// Depends on rrs_pkg, rrs_scan and rrs_outq.
//
// Usage:
//   Stream a code section into the input channel one byte per word, with
//   last_byte set on the final byte. An offset is tested as a possible
//   start once seven bytes from it have arrived; at the final byte the
//   offset six bytes from the end is tested too. A RIP-relative hit yields
//   a reference word; the final byte adds a summary word with the count.
//   Configure section_base_address (index 0) and reference_limit (index 1)
//   through the write port while the block is idle; unknown indexes drop.
// Timing:
//   Input words pass through one input register, the scan logic and a
//   four-entry result queue. A result word is written to the queue when
//   its byte leaves the input register. One byte is accepted per cycle
//   while the queue has room; a byte yields at most two result words, and
//   the input holds off while the queue has fewer than two free entries.
// Reset and stalls:
//   Synchronous reset clears the scan state and queue, sets the base to
//   zero and the limit to 65535. When the receiver stalls, results wait in
//   the queue and the next byte in the input register; the input stops
//   taking bytes once both are full, and nothing is lost.
`default_nettype none

module rip_relative_reference_scanner_unit #(
    parameter int POSITION_WIDTH = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire rrs_pkg::t_in_word            i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output rrs_pkg::t_out_word                o_out_data,
    input  wire                               i_cfg_wr_en,
    input  wire [rrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [63:0]                        i_cfg_wdata
);
    import rrs_pkg::*;

    logic [63:0] r_base;
    logic [15:0] r_limit;
    logic        r_in_vld;
    t_in_word    r_in_word;
    logic        adv;
    logic        room;
    logic        in_take;
    t_push       push;

    // Configuration registers; writes to unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= 16'hFFFF;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx == REG_SECTION_BASE) begin
                r_base <= i_cfg_wdata;
            end
            if (i_cfg_idx == REG_REF_LIMIT) begin
                r_limit <= i_cfg_wdata[15:0];
            end
        end
    end

    // Advance the held byte once the queue has room for both possible words
    assign adv        = r_in_vld && room;
    assign o_in_ready = !r_in_vld || adv;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_data;
        end
    end

    rrs_scan #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_word  (r_in_word),
        .i_base  (r_base),
        .i_limit (r_limit),
        .o_push  (push)
    );

    rrs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_data)
    );

endmodule

`default_nettype wire
